// ===== rtl/fxalu_pkg.sv =====
package fxalu_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 8;
  // scaled dividend width: a << FRAC_BITS kept without loss
  localparam int NUM_W      = DATA_W + FRAC_BITS;
  // quotient bits resolved in each divider stage
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DD_W       = DIV_STAGES * DIV_STEP;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_GT       = 4'd4,
    OP_LT       = 4'd5,
    OP_GE       = 4'd6,
    OP_LE       = 4'd7,
    OP_EQ       = 4'd8,
    OP_NE       = 4'd9,
    OP_MIN      = 4'd10,
    OP_MAX      = 4'd11,
    OP_INC      = 4'd12,
    OP_DEC      = 4'd13,
    OP_FROM_INT = 4'd14,
    OP_TO_INT   = 4'd15
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [DATA_W-1:0]  simple;
    logic               flag;
    logic               dz;
    logic [DATA_W-1:0]  mres;
    logic               neg;
    logic [DATA_W-1:0]  dvs;
    logic [DATA_W-1:0]  rem;
    logic [DD_W-1:0]    dd;
  } pipe_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_raw;
    logic              flag;
    logic              div_zero;
  } res_t;

endpackage

// ===== rtl/fxalu_front.sv =====
module fxalu_front
  import fxalu_pkg::*;
(
  input  logic [3:0]               op,
  input  logic signed [DATA_W-1:0] a_raw,
  input  logic signed [DATA_W-1:0] b_raw,
  output pipe_t                    front
);

  op_t                       opc;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [NUM_W-1:0]   num;
  logic [NUM_W-1:0]          num_mag;
  logic [DATA_W-1:0]         b_mag;
  logic                      lt;
  logic                      gt;
  logic                      eq;

  always_comb begin
    opc  = op_t'(op);
    prod = (2*DATA_W)'(a_raw) * (2*DATA_W)'(b_raw);
    num  = NUM_W'(a_raw) <<< FRAC_BITS;
    num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    b_mag   = b_raw[DATA_W-1] ? DATA_W'(-b_raw) : DATA_W'(b_raw);
    lt = a_raw < b_raw;
    gt = a_raw > b_raw;
    eq = a_raw == b_raw;

    front.op     = opc;
    front.simple = '0;
    front.flag   = 1'b0;
    front.dz     = (opc == OP_DIV) && (b_raw == '0);
    // floor shift of the full product, wrapped to the data width
    front.mres   = prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
    front.neg    = a_raw[DATA_W-1] ^ b_raw[DATA_W-1];
    front.dvs    = b_mag;
    front.rem    = '0;
    front.dd     = DD_W'(num_mag);

    case (opc)
      OP_ADD:      front.simple = DATA_W'(a_raw + b_raw);
      OP_SUB:      front.simple = DATA_W'(a_raw - b_raw);
      OP_GT:       front.flag   = gt;
      OP_LT:       front.flag   = lt;
      OP_GE:       front.flag   = !lt;
      OP_LE:       front.flag   = !gt;
      OP_EQ:       front.flag   = eq;
      OP_NE:       front.flag   = !eq;
      OP_MIN:      front.simple = lt ? a_raw : b_raw;
      OP_MAX:      front.simple = gt ? a_raw : b_raw;
      OP_INC:      front.simple = DATA_W'(a_raw + 32'sd1);
      OP_DEC:      front.simple = DATA_W'(a_raw - 32'sd1);
      OP_FROM_INT: front.simple = DATA_W'(a_raw << FRAC_BITS);
      OP_TO_INT:   front.simple = DATA_W'(a_raw >>> FRAC_BITS);
      default:     front.simple = '0;
    endcase
  end

endmodule

// ===== rtl/fxalu_div_stage.sv =====
module fxalu_div_stage
  import fxalu_pkg::*;
(
  input  pipe_t s_in,
  output pipe_t s_out
);

  // restoring division, a few quotient bits shifted into dd per stage
  always_comb begin
    logic [DATA_W:0] sh;
    s_out = s_in;
    for (int i = 0; i < DIV_STEP; i++) begin
      sh = {s_out.rem, s_out.dd[DD_W-1]};
      s_out.dd = {s_out.dd[DD_W-2:0], 1'b0};
      if (sh >= {1'b0, s_out.dvs}) begin
        sh = sh - {1'b0, s_out.dvs};
        s_out.dd[0] = 1'b1;
      end
      s_out.rem = sh[DATA_W-1:0];
    end
  end

endmodule

// ===== rtl/fxalu_back.sv =====
module fxalu_back
  import fxalu_pkg::*;
(
  input  pipe_t s_in,
  output res_t  res
);

  logic [DATA_W-1:0] q;
  logic [DATA_W-1:0] qs;

  always_comb begin
    // quotient magnitude wraps to the data width before the sign is applied
    q  = s_in.dd[DATA_W-1:0];
    qs = s_in.neg ? DATA_W'(~q + 1'b1) : q;
    res.flag     = s_in.flag;
    res.div_zero = s_in.dz;
    case (s_in.op)
      OP_MUL:  res.result_raw = s_in.mres;
      OP_DIV:  res.result_raw = s_in.dz ? '0 : qs;
      default: res.result_raw = s_in.simple;
    endcase
  end

endmodule

// ===== rtl/fixed_point_q24_8_alu_unit.sv =====
// Signed Q24.8 fixed-point ALU. Takes one transaction per clock while not
// stalled and returns one result per transaction in order. The 32x32
// multiplier and operand preparation sit ahead of the first register, then
// a register follows each divider stage, where the 40-bit scaled quotient is
// resolved four bits per stage, and the output register follows sign fixup
// and result select. Every opcode runs through the same stages, so order
// is kept. A stall on the result side only holds back stages that are
// occupied; bubbles collapse.
module fixed_point_q24_8_alu_unit
  import fxalu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_stall,
  input  logic [3:0]               op,
  input  logic signed [DATA_W-1:0] a_raw,
  input  logic signed [DATA_W-1:0] b_raw,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic signed [DATA_W-1:0] result_raw,
  output logic                     flag,
  output logic                     div_zero
);

  localparam int NP = DIV_STAGES + 1;

  pipe_t            front;
  pipe_t            pipe      [NP];
  pipe_t            step_out  [DIV_STAGES];
  logic [NP-1:0]    vld;
  logic [NP:0]      adv;
  res_t             back;

  fxalu_front u_front (
    .op    (op),
    .a_raw (a_raw),
    .b_raw (b_raw),
    .front (front)
  );

  // a stage moves when it is empty or its successor moves
  assign adv[NP] = !res_valid || !res_stall;
  genvar g;
  generate
    for (g = 0; g < NP; g++) begin : g_adv
      assign adv[g] = !vld[g] || adv[g+1];
    end
  endgenerate

  assign cmd_stall = !adv[0];

  generate
    for (g = 0; g < DIV_STAGES; g++) begin : g_div
      fxalu_div_stage u_stage (
        .s_in  (pipe[g]),
        .s_out (step_out[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= cmd_valid;
      end
      for (int i = 1; i < NP; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pipe[0] <= front;
    end
    for (int i = 1; i < NP; i++) begin
      if (adv[i]) begin
        pipe[i] <= step_out[i-1];
      end
    end
  end

  fxalu_back u_back (
    .s_in (pipe[NP-1]),
    .res  (back)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv[NP]) begin
      res_valid <= vld[NP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NP]) begin
      result_raw <= back.result_raw;
      flag       <= back.flag;
      div_zero   <= back.div_zero;
    end
  end

endmodule
